// File: rtl/tbdlp_pkg.sv
// Shared types, codes, reset values and the per-button debounce step.
package tbdlp_pkg;

    localparam int DEB_W      = 8;
    localparam int HOLD_W     = 16;
    localparam int DUTY_W     = 8;
    localparam int KEY_W      = 2;
    localparam int CFG_ADDR_W = 4;
    localparam int CFG_DATA_W = 32;

    localparam logic [DEB_W-1:0]  DEBOUNCE_RESET = 8'd5;
    localparam logic [HOLD_W-1:0] HOLD_RESET     = 16'd1550;
    localparam logic [DUTY_W-1:0] DUTY_RESET     = 8'd8;

    // Register index, taken from paddr word offset
    typedef enum logic [1:0] {
        REG_DEBOUNCE = 2'd0,
        REG_HOLD     = 2'd1,
        REG_LAMP     = 2'd2
    } cfg_idx_t;

    // Key codes: horizontal arrow in portrait, vertical arrow in landscape
    typedef enum logic [KEY_W-1:0] {
        KEY_NONE  = 2'd0,
        KEY_HORIZ = 2'd1,
        KEY_VERT  = 2'd2
    } key_t;

    typedef enum logic {
        MODE_LANDSCAPE = 1'b0,
        MODE_PORTRAIT  = 1'b1
    } mode_t;

    typedef enum logic [1:0] {
        EV_NONE    = 2'd0,
        EV_PRESS   = 2'd1,
        EV_RELEASE = 2'd2
    } btn_ev_t;

    typedef struct packed {
        logic             pressed;
        logic             prev_level;
        logic             settle_active;
        logic [DEB_W-1:0] settle_count;
    } btn_state_t;

    typedef struct packed {
        btn_state_t st;
        btn_ev_t    ev;
    } btn_result_t;

    typedef struct packed {
        key_t              left_key;
        key_t              right_key;
        mode_t             view_mode;
        logic              mode_changed;
        logic              switch_fault;
        logic [DUTY_W-1:0] landscape_duty;
        logic [DUTY_W-1:0] portrait_duty;
    } result_t;

    // One tick of a button: watch for an edge away from the debounced state,
    // settle for deb+1 ticks, then toggle.
    function automatic btn_result_t button_step(input btn_state_t b, input logic level,
                                                input logic [DEB_W-1:0] deb);
        btn_result_t r;
        logic        edge_seen;
        r.st = b;
        r.ev = EV_NONE;
        edge_seen = b.pressed ? (!b.prev_level && level) : (b.prev_level && !level);
        r.st.prev_level = level;
        if (edge_seen)
        begin
            r.st.settle_active = 1'b1;
            r.st.settle_count  = '0;
        end
        else if (b.settle_active)
        begin
            if (b.settle_count >= deb)
            begin
                r.st.settle_active = 1'b0;
                r.st.settle_count  = '0;
                r.st.pressed       = !b.pressed;
                r.ev               = b.pressed ? EV_RELEASE : EV_PRESS;
            end
            else
            begin
                r.st.settle_count = b.settle_count + 1'b1;
            end
        end
        return r;
    endfunction

endpackage

// File: rtl/tbdlp_if.sv
// Valid/ready channel interfaces for tick items and result items.
interface tbdlp_in_if;
    logic valid;
    logic ready;
    logic left_level;
    logic right_level;

    modport source (output valid, output left_level, output right_level, input ready);
    modport sink   (input valid, input left_level, input right_level, output ready);
endinterface

interface tbdlp_out_if;
    import tbdlp_pkg::*;
    logic              valid;
    logic              ready;
    logic [KEY_W-1:0]  left_key;
    logic [KEY_W-1:0]  right_key;
    logic              view_mode;
    logic              mode_changed;
    logic              switch_fault;
    logic [DUTY_W-1:0] landscape_duty;
    logic [DUTY_W-1:0] portrait_duty;

    modport source (output valid, output left_key, output right_key, output view_mode,
                    output mode_changed, output switch_fault, output landscape_duty,
                    output portrait_duty, input ready);
    modport sink   (input valid, input left_key, input right_key, input view_mode,
                    input mode_changed, input switch_fault, input landscape_duty,
                    input portrait_duty, output ready);
endinterface

// File: rtl/two_button_debounce_long_press_mode.sv
// Top level: two-button debounce, long-press view-mode switch and lamp duties.

// Takes one millisecond tick item per clock cycle. The button and hold
// state is updated in the same cycle the tick is accepted, and the result
// item appears in the output register on the next cycle; ready stays high
// while that register is empty or is being taken, so ticks stream at one per
// cycle under no backpressure. Registers at 0x0 (debounce_ticks), 0x4
// (hold_ticks) and 0x8 (lamp_duty) are written over the APB port; the user
// must do so only while no ticks are in flight (the block does not enforce
// this). A button toggles on the (debounce_ticks+1)-th tick after its last
// edge and the mode switch fires on the (hold_ticks+1)-th tick after a press.
module two_button_debounce_long_press_mode (
    input  logic                               clk,
    input  logic                               rst_n,
    tbdlp_in_if.sink                           in_ch,
    tbdlp_out_if.source                        out_ch,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [tbdlp_pkg::CFG_ADDR_W-1:0]   paddr,
    input  logic [tbdlp_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic [tbdlp_pkg::CFG_DATA_W-1:0]   prdata,
    output logic                               pready
);
    import tbdlp_pkg::*;

    // Configuration registers
    logic [DEB_W-1:0]  debounce_reg;
    logic [HOLD_W-1:0] hold_ticks_reg;
    logic [DUTY_W-1:0] duty_reg;

    // Tick state
    btn_state_t        left_reg, left_next;
    btn_state_t        right_reg, right_next;
    logic              hold_active_reg, hold_active_next;
    logic [HOLD_W-1:0] hold_count_reg, hold_count_next;
    mode_t             mode_reg, mode_next;

    // Output register
    logic              out_valid_reg;
    result_t           result_reg, result_next;

    logic              accept;
    logic              cfg_write;
    cfg_idx_t          cfg_idx;
    btn_result_t       left_res, right_res;
    logic              started;
    key_t              lkey, rkey;
    logic              changed, fault;

    assign cfg_idx   = cfg_idx_t'(paddr[CFG_ADDR_W-1:2]);
    assign cfg_write = psel && penable && pwrite && pready;
    assign pready    = 1'b1;

    // Register write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg   <= DEBOUNCE_RESET;
            hold_ticks_reg <= HOLD_RESET;
            duty_reg       <= DUTY_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_idx)
                REG_DEBOUNCE: debounce_reg   <= pwdata[DEB_W-1:0];
                REG_HOLD:     hold_ticks_reg <= pwdata[HOLD_W-1:0];
                REG_LAMP:     duty_reg       <= pwdata[DUTY_W-1:0];
                default:      ;
            endcase
        end
    end

    // Register read
    always_comb
    begin
        case (cfg_idx)
            REG_DEBOUNCE: prdata = {{(CFG_DATA_W-DEB_W){1'b0}}, debounce_reg};
            REG_HOLD:     prdata = {{(CFG_DATA_W-HOLD_W){1'b0}}, hold_ticks_reg};
            REG_LAMP:     prdata = {{(CFG_DATA_W-DUTY_W){1'b0}}, duty_reg};
            default:      prdata = '0;
        endcase
    end

    // Handshake: take a tick whenever the output register is free or draining
    assign in_ch.ready = !out_valid_reg || out_ch.ready;
    assign accept      = in_ch.valid && in_ch.ready;

    // Per-tick update: left button, right button, then the hold timer
    always_comb
    begin
        left_res  = button_step(left_reg, in_ch.left_level, debounce_reg);
        right_res = button_step(right_reg, in_ch.right_level, debounce_reg);
        left_next  = left_res.st;
        right_next = right_res.st;
        hold_active_next = hold_active_reg;
        hold_count_next  = hold_count_reg;
        mode_next        = mode_reg;
        started          = 1'b0;
        lkey             = KEY_NONE;
        rkey             = KEY_NONE;
        changed          = 1'b0;
        fault            = 1'b0;

        if (left_res.ev == EV_PRESS)
        begin
            lkey             = (mode_reg == MODE_PORTRAIT) ? KEY_HORIZ : KEY_VERT;
            hold_active_next = 1'b1;
            hold_count_next  = '0;
            started          = 1'b1;
        end
        else if (left_res.ev == EV_RELEASE)
        begin
            hold_active_next = 1'b0;
            hold_count_next  = '0;
            started          = 1'b0;
        end

        if (right_res.ev == EV_PRESS)
        begin
            rkey             = (mode_reg == MODE_PORTRAIT) ? KEY_HORIZ : KEY_VERT;
            hold_active_next = 1'b1;
            hold_count_next  = '0;
            started          = 1'b1;
        end
        else if (right_res.ev == EV_RELEASE)
        begin
            hold_active_next = 1'b0;
            hold_count_next  = '0;
            started          = 1'b0;
        end

        // Long press: switch mode if the matching button is held, else flag a fault
        if (hold_active_next && !started)
        begin
            if (hold_count_next >= hold_ticks_reg)
            begin
                hold_active_next = 1'b0;
                hold_count_next  = '0;
                if (mode_reg == MODE_PORTRAIT && right_next.pressed)
                begin
                    mode_next = MODE_LANDSCAPE;
                    changed   = 1'b1;
                end
                else if (mode_reg == MODE_LANDSCAPE && left_next.pressed)
                begin
                    mode_next = MODE_PORTRAIT;
                    changed   = 1'b1;
                end
                else
                begin
                    fault = 1'b1;
                end
            end
            else
            begin
                hold_count_next = hold_count_next + 1'b1;
            end
        end

        result_next.left_key       = lkey;
        result_next.right_key      = rkey;
        result_next.view_mode      = mode_next;
        result_next.mode_changed   = changed;
        result_next.switch_fault   = fault;
        result_next.landscape_duty = (mode_next == MODE_PORTRAIT) ? '0 : duty_reg;
        result_next.portrait_duty  = (mode_next == MODE_PORTRAIT) ? duty_reg : '0;
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg        <= '{pressed: 1'b0, prev_level: 1'b1, settle_active: 1'b0,
                                 settle_count: '0};
            right_reg       <= '{pressed: 1'b0, prev_level: 1'b1, settle_active: 1'b0,
                                 settle_count: '0};
            hold_active_reg <= 1'b0;
            hold_count_reg  <= '0;
            mode_reg        <= MODE_PORTRAIT;
        end
        else if (accept)
        begin
            left_reg        <= left_next;
            right_reg       <= right_next;
            hold_active_reg <= hold_active_next;
            hold_count_reg  <= hold_count_next;
            mode_reg        <= mode_next;
        end
    end

    // Output register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            result_reg <= result_next;
        end
    end

    assign out_ch.valid          = out_valid_reg;
    assign out_ch.left_key       = result_reg.left_key;
    assign out_ch.right_key      = result_reg.right_key;
    assign out_ch.view_mode      = result_reg.view_mode;
    assign out_ch.mode_changed   = result_reg.mode_changed;
    assign out_ch.switch_fault   = result_reg.switch_fault;
    assign out_ch.landscape_duty = result_reg.landscape_duty;
    assign out_ch.portrait_duty  = result_reg.portrait_duty;

`ifndef SYNTHESIS
    // An accepted tick always leaves a result waiting
    a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> out_valid_reg)
        else $error("accepted tick produced no result");

    // A tick that emits a key started or cancelled the hold timer, so no expiry
    a_key_no_expiry: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (result_reg.left_key != KEY_NONE ||
                           result_reg.right_key != KEY_NONE))
        |-> (!result_reg.mode_changed && !result_reg.switch_fault))
        else $error("key press coincides with hold expiry");

    // A mode change and a fault never come from the same expiry
    a_change_xor_fault: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(result_reg.mode_changed && result_reg.switch_fault))
        else $error("mode change and switch fault together");

    // Idle settle timers sit at zero
    a_settle_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (left_reg.settle_active || left_reg.settle_count == '0) &&
        (right_reg.settle_active || right_reg.settle_count == '0))
        else $error("settle count nonzero while idle");

    // A reported mode change flips the mode held before the tick
    a_change_flips: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && result_next.mode_changed) |-> (mode_next != mode_reg))
        else $error("mode change without a mode flip");
`endif

endmodule

// File: test/tb_two_button_debounce_long_press_mode.sv
// Testbench for the two-button debounce and long-press view-mode switch.
module tb_two_button_debounce_long_press_mode;
    timeunit 1ns;
    timeprecision 1ps;

    import tbdlp_pkg::*;

    // Debounce state of one button as the predictor tracks it
    typedef struct {
        logic             down;
        logic             last_level;
        logic             settling;
        logic [DEB_W-1:0] settle_cnt;
    } btn_model_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    tbdlp_in_if  in_ch();
    tbdlp_out_if out_ch();

    two_button_debounce_long_press_mode i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Predictor copy of the registers and the block state
    logic [DEB_W-1:0]  deb_cfg;
    logic [HOLD_W-1:0] hold_cfg;
    logic [DUTY_W-1:0] duty_cfg;
    btn_model_t        lbtn;
    btn_model_t        rbtn;
    logic              hold_on;
    logic [HOLD_W-1:0] hold_cnt;
    mode_t             view;

    // Tick results predicted but not yet seen on the output
    result_t pending_reports[$];

    int errors        = 0;
    int ticks_sent    = 0;
    int reports_seen  = 0;
    int keys_seen     = 0;
    int switches_seen = 0;
    int faults_seen   = 0;
    int burst_left    = 0;

    always #10 clk = ~clk;

    // One tick of one button: edge away from the debounced state, settle, toggle
    task automatic debounce_button(inout btn_model_t b, input logic lvl, output btn_ev_t ev);
        logic moved;
        ev = EV_NONE;
        moved = b.down ? (!b.last_level && lvl) : (b.last_level && !lvl);
        b.last_level = lvl;
        if (moved)
        begin
            b.settling   = 1'b1;
            b.settle_cnt = '0;
        end
        else if (b.settling)
        begin
            if (b.settle_cnt >= deb_cfg)
            begin
                b.settling   = 1'b0;
                b.settle_cnt = '0;
                b.down       = !b.down;
                ev           = b.down ? EV_PRESS : EV_RELEASE;
            end
            else
            begin
                b.settle_cnt = b.settle_cnt + 1'b1;
            end
        end
    endtask

    // Expected result of one tick; left first, then right, then the hold timer
    task automatic predict_tick(input logic l, input logic r, output result_t want);
        btn_ev_t ev;
        logic    started;
        want.left_key     = KEY_NONE;
        want.right_key    = KEY_NONE;
        want.mode_changed = 1'b0;
        want.switch_fault = 1'b0;
        started = 1'b0;

        debounce_button(lbtn, l, ev);
        if (ev == EV_PRESS)
        begin
            want.left_key = (view == MODE_PORTRAIT) ? KEY_HORIZ : KEY_VERT;
            hold_on  = 1'b1;
            hold_cnt = '0;
            started  = 1'b1;
        end
        else if (ev == EV_RELEASE)
        begin
            hold_on  = 1'b0;
            hold_cnt = '0;
            started  = 1'b0;
        end

        debounce_button(rbtn, r, ev);
        if (ev == EV_PRESS)
        begin
            want.right_key = (view == MODE_PORTRAIT) ? KEY_HORIZ : KEY_VERT;
            hold_on  = 1'b1;
            hold_cnt = '0;
            started  = 1'b1;
        end
        else if (ev == EV_RELEASE)
        begin
            hold_on  = 1'b0;
            hold_cnt = '0;
            started  = 1'b0;
        end

        // Hold timer never fires on the tick that (re)started it
        if (hold_on && !started)
        begin
            if (hold_cnt >= hold_cfg)
            begin
                hold_on  = 1'b0;
                hold_cnt = '0;
                if (view == MODE_PORTRAIT && rbtn.down)
                begin
                    view = MODE_LANDSCAPE;
                    want.mode_changed = 1'b1;
                end
                else if (view == MODE_LANDSCAPE && lbtn.down)
                begin
                    view = MODE_PORTRAIT;
                    want.mode_changed = 1'b1;
                end
                else
                begin
                    want.switch_fault = 1'b1;
                end
            end
            else
            begin
                hold_cnt = hold_cnt + 1'b1;
            end
        end

        want.view_mode      = view;
        want.landscape_duty = (view == MODE_LANDSCAPE) ? duty_cfg : '0;
        want.portrait_duty  = (view == MODE_PORTRAIT) ? duty_cfg : '0;

        keys_seen     += (want.left_key != KEY_NONE) + (want.right_key != KEY_NONE);
        switches_seen += want.mode_changed;
        faults_seen   += want.switch_fault;
    endtask

    task automatic check_field(input string fname, input logic [7:0] want, input logic [7:0] got);
        if (got !== want)
        begin
            errors++;
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, fname, want, got);
        end
    endtask

    // Result checker: every accepted result against the oldest expectation
    always @(posedge clk)
    begin : check_reports
        result_t want;
        if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
        begin
            reports_seen++;
            if (pending_reports.size() == 0)
            begin
                errors++;
                $display("%0t ns: unexpected result item, expected none, actual keys %0d/%0d",
                         $time, out_ch.left_key, out_ch.right_key);
            end
            else
            begin
                want = pending_reports.pop_front();
                check_field("left_key", 8'(want.left_key), 8'(out_ch.left_key));
                check_field("right_key", 8'(want.right_key), 8'(out_ch.right_key));
                check_field("view_mode", 8'(want.view_mode), 8'(out_ch.view_mode));
                check_field("mode_changed", 8'(want.mode_changed), 8'(out_ch.mode_changed));
                check_field("switch_fault", 8'(want.switch_fault), 8'(out_ch.switch_fault));
                check_field("landscape_duty", want.landscape_duty, out_ch.landscape_duty);
                check_field("portrait_duty", want.portrait_duty, out_ch.portrait_duty);
            end
        end
    end

    // Receiver: stall pattern that cycles through free-running, periodic,
    // random and bursty stalls
    initial
    begin : result_sink
        int rx_cyc;
        rx_cyc = 0;
        out_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            rx_cyc++;
            case (rx_cyc[8:7])
                2'd0:    out_ch.ready <= 1'b1;
                2'd1:    out_ch.ready <= (rx_cyc % 3) != 0;
                2'd2:    out_ch.ready <= 1'($urandom_range(0, 1));
                default: out_ch.ready <= rx_cyc[4:2] != 3'd5;
            endcase
        end
    end

    // Send one tick item; the sender works in bursts with random gaps
    task automatic send_tick(input logic l, input logic r);
        result_t want;
        int      gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        in_ch.valid       <= 1'b1;
        in_ch.left_level  <= l;
        in_ch.right_level <= r;
        @(posedge clk);
        while (in_ch.ready !== 1'b1)
            @(posedge clk);
        predict_tick(l, r, want);
        pending_reports.push_back(want);
        ticks_sent++;
        burst_left--;
    endtask

    task automatic hold_levels(input logic l, input logic r, input int n);
        repeat (n) send_tick(l, r);
    endtask

    // Stop sending and wait until every expected result has come
    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        while (pending_reports.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    // APB write followed by a read-back of the same register
    task automatic program_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
        logic [CFG_DATA_W-1:0] stored;
        case (idx)
            REG_DEBOUNCE: stored = value & 32'h0000_00FF;
            REG_HOLD:     stored = value & 32'h0000_FFFF;
            default:      stored = value & 32'h0000_00FF;
        endcase
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CFG_ADDR_W'({idx, 2'b00});
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (pready !== 1'b1)
            @(posedge clk);
        case (idx)
            REG_DEBOUNCE: deb_cfg  = stored[DEB_W-1:0];
            REG_HOLD:     hold_cfg = stored[HOLD_W-1:0];
            default:      duty_cfg = stored[DUTY_W-1:0];
        endcase

        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (pready !== 1'b1)
            @(posedge clk);
        if (prdata !== stored)
        begin
            errors++;
            $display("%0t ns: register %s read-back mismatch, expected %0d, actual %0d",
                     $time, idx.name(), stored, prdata);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // Reprogram all three registers once the block is idle; junk fills the
    // bits above each register's width
    task automatic set_config(input int deb, input int hold, input int duty, input logic junk);
        logic [CFG_DATA_W-1:0] v;
        wait_idle();
        v = deb;
        if (junk)
            v[31:DEB_W] = (CFG_DATA_W-DEB_W)'($urandom);
        program_reg(REG_DEBOUNCE, v);
        v = hold;
        if (junk)
            v[31:HOLD_W] = (CFG_DATA_W-HOLD_W)'($urandom);
        program_reg(REG_HOLD, v);
        v = duty;
        if (junk)
            v[31:DUTY_W] = (CFG_DATA_W-DUTY_W)'($urandom);
        program_reg(REG_LAMP, v);
    endtask

    // Reset values: default debounce, default duty in portrait
    task automatic test_reset_defaults();
        hold_levels(1'b0, 1'b1, 8);
        hold_levels(1'b1, 1'b1, 8);
    endtask

    // Fast timing: each gesture of the mode switch and its corner cases
    task automatic test_directed_gestures();
        set_config(0, 1, 255, 1'b0);
        // right held in portrait: right arrow, then switch to landscape
        hold_levels(1'b1, 1'b0, 4);
        hold_levels(1'b1, 1'b1, 2);
        // left held in landscape: up arrow, then back to portrait
        hold_levels(1'b0, 1'b1, 4);
        hold_levels(1'b1, 1'b1, 2);
        // left held in portrait: hold expires with a fault
        hold_levels(1'b0, 1'b1, 4);
        hold_levels(1'b1, 1'b1, 2);
        // both at once, then right released early cancels the hold
        hold_levels(1'b0, 1'b0, 2);
        hold_levels(1'b0, 1'b1, 2);
        hold_levels(1'b1, 1'b1, 2);
        // a short glitch still toggles the state when the timer fires
        send_tick(1'b0, 1'b1);
        hold_levels(1'b1, 1'b1, 3);
        send_tick(1'b0, 1'b1);
        hold_levels(1'b1, 1'b1, 2);
    endtask

    // Widest settle and hold settings, lamp off; the release edge is left
    // settling and finishes under the next settings
    task automatic test_long_debounce();
        set_config(255, 65535, 0, 1'b0);
        hold_levels(1'b0, 1'b1, 258);
        hold_levels(1'b1, 1'b1, 2);
    endtask

    // Random press gestures with chatter, noise and idle pauses
    task automatic test_random_sessions(input int n_ticks);
        int   first;
        int   next_cfg;
        int   span;
        int   deb;
        int   hold;
        int   duty;
        logic ll;
        logic rl;
        first    = ticks_sent;
        next_cfg = 0;
        while (ticks_sent - first < n_ticks)
        begin
            if (ticks_sent - first >= next_cfg)
            begin
                case ($urandom_range(0, 4))
                    0:       deb = 0;
                    1:       deb = 1;
                    2, 3:    deb = $urandom_range(2, 4);
                    default: deb = $urandom_range(5, 12);
                endcase
                case ($urandom_range(0, 5))
                    0:       hold = 0;
                    1:       hold = 1;
                    2:       hold = 65535;
                    default: hold = $urandom_range(2, 16);
                endcase
                case ($urandom_range(0, 3))
                    0:       duty = 0;
                    1:       duty = 255;
                    default: duty = $urandom_range(0, 255);
                endcase
                set_config(deb, hold, duty, 1'($urandom_range(0, 1)));
                next_cfg = ticks_sent - first + $urandom_range(50, 90);
            end
            span = deb_cfg + ((hold_cfg > 24) ? 24 : hold_cfg) + 6;
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5, 6:
                begin
                    // pressed level per button: left only, right only or both
                    case ($urandom_range(0, 2))
                        0:       begin ll = 1'b0; rl = 1'b1; end
                        1:       begin ll = 1'b1; rl = 1'b0; end
                        default: begin ll = 1'b0; rl = 1'b0; end
                    endcase
                    repeat ($urandom_range(0, 3))
                        send_tick(ll | 1'($urandom_range(0, 1)), rl | 1'($urandom_range(0, 1)));
                    hold_levels(ll, rl, $urandom_range(0, span));
                    repeat ($urandom_range(0, 3))
                        send_tick(ll | 1'($urandom_range(0, 1)), rl | 1'($urandom_range(0, 1)));
                    hold_levels(1'b1, 1'b1, $urandom_range(0, deb_cfg + 4));
                end
                7, 8:
                begin
                    repeat ($urandom_range(1, 10))
                        send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                end
                default:
                begin
                    wait_idle();
                end
            endcase
        end
    endtask

    initial
    begin
        rst_n             = 1'b0;
        psel              = 1'b0;
        penable           = 1'b0;
        pwrite            = 1'b0;
        paddr             = '0;
        pwdata            = '0;
        in_ch.valid       = 1'b0;
        in_ch.left_level  = 1'b1;
        in_ch.right_level = 1'b1;

        deb_cfg  = DEBOUNCE_RESET;
        hold_cfg = HOLD_RESET;
        duty_cfg = DUTY_RESET;
        lbtn     = '{1'b0, 1'b1, 1'b0, '0};
        rbtn     = '{1'b0, 1'b1, 1'b0, '0};
        hold_on  = 1'b0;
        hold_cnt = '0;
        view     = MODE_PORTRAIT;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_directed_gestures();
        test_long_debounce();
        test_random_sessions(200);

        wait_idle();
        repeat (8) @(posedge clk);

        $display("Sent %0d ticks and checked %0d result items across reset, fast and widest timing.",
                 ticks_sent, reports_seen);
        $display("Predicted %0d arrow keys, %0d mode switches and %0d switch faults.",
                 keys_seen, switches_seen, faults_seen);
        if (errors == 0 && pending_reports.size() == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // Watchdog
    initial
    begin
        #20_000_000;
        $display("Timeout with %0d results outstanding", pending_reports.size());
        $display("CHECK FAILED");
        $finish;
    end

endmodule
